/* hw/rtl/fvc_pkg.sv */
// Shared types and constants of the frustum volume classifier.
// No dependencies; imported by every other file of the block.
`timescale 1ns / 1ps
`default_nettype none

package fvc_pkg;

   // Plane register file.
   localparam int NUM_PLANE_REGS = 6;
   localparam int PLANE_W        = 64;
   localparam int PLANE_IDX_W    = 3;
   localparam int COEF_W         = 16;
   localparam int NORMAL_FRAC    = 14;

   // Configuration port: 64-bit registers at byte address 8*i.
   localparam int CSR_ADDR_W     = 6;
   localparam int CSR_DATA_W     = 64;
   localparam int CSR_BYTE_BITS  = 3;

   // Defaults of the top level parameters.
   localparam int DEF_PLANE_COUNT = 6;
   localparam int DEF_COORD_BITS  = 16;

   // Volume type of an item.
   localparam int CMD_W = 2;
   localparam logic [CMD_W-1:0] CMD_POINT  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SPHERE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_BOX    = 2'd2;

   // Result classes.
   localparam int VIS_W = 2;
   localparam logic [VIS_W-1:0] VIS_OUTSIDE   = 2'd0;
   localparam logic [VIS_W-1:0] VIS_INSIDE    = 2'd1;
   localparam logic [VIS_W-1:0] VIS_INTERSECT = 2'd2;

   // Load enables of the two register stages inside a plane distance unit.
   typedef struct packed {
      logic mul_en;
      logic sum_en;
   } fvc_stage_en_type;

endpackage

`default_nettype wire

/* hw/rtl/fvc_csr.sv */
// Plane register file with its APB-style configuration port.
// Depends on fvc_pkg for register count, widths and address layout.
`timescale 1ns / 1ps
`default_nettype none

module fvc_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [fvc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [fvc_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [fvc_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready,
   output logic [fvc_pkg::PLANE_W-1:0]    planes [fvc_pkg::NUM_PLANE_REGS]
);
   import fvc_pkg::*;

   logic [PLANE_W-1:0]     plane_ff [NUM_PLANE_REGS];
   logic [PLANE_W-1:0]     plane_in [NUM_PLANE_REGS];
   logic [PLANE_IDX_W-1:0] reg_idx;
   logic                   idx_valid;
   logic                   wr_en;

   assign reg_idx   = csr_paddr[CSR_ADDR_W-1:CSR_BYTE_BITS];
   assign idx_valid = (int'(reg_idx) < NUM_PLANE_REGS);
   assign wr_en     = csr_psel && csr_penable && csr_pwrite && idx_valid;
   assign csr_pready = 1'b1;

   always_comb begin
      for (int i = 0; i < NUM_PLANE_REGS; i++) begin
         plane_in[i] = (wr_en && (int'(reg_idx) == i)) ? csr_pwdata : plane_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_PLANE_REGS; i++) begin
         if (reset) begin
            plane_ff[i] <= '0;
         end else begin
            plane_ff[i] <= plane_in[i];
         end
      end
   end

   // Addresses past the last plane read as zero.
   assign csr_prdata = idx_valid ? plane_ff[reg_idx] : '0;
   assign planes     = plane_ff;

endmodule

`default_nettype wire

/* hw/rtl/fvc_dist.sv */
// Signed distance unit for one plane: corner selection and multiply stage,
// then the sum stage. Depends on fvc_pkg for plane layout and stage enables.
`timescale 1ns / 1ps
`default_nettype none

module fvc_dist #(
   parameter int COORD_BITS = fvc_pkg::DEF_COORD_BITS,
   parameter int DIST_W     = 34
) (
   input  logic                          clock,
   input  fvc_pkg::fvc_stage_en_type     stage_en,
   input  logic [fvc_pkg::PLANE_W-1:0]   plane,
   input  logic                          box_sel,
   input  logic signed [COORD_BITS-1:0]  lo_pt [3],
   input  logic signed [COORD_BITS-1:0]  hi_pt [3],
   output logic signed [DIST_W-1:0]      dist_pos,
   output logic signed [DIST_W-1:0]      dist_neg
);
   import fvc_pkg::*;

   localparam int PROD_W = COORD_BITS + COEF_W;

   logic signed [COEF_W-1:0]     coef [3];
   logic signed [COEF_W-1:0]     offset;
   logic signed [COORD_BITS-1:0] pos_pt [3];
   logic signed [COORD_BITS-1:0] neg_pt [3];
   logic signed [PROD_W-1:0]     prod_pos_in [3];
   logic signed [PROD_W-1:0]     prod_neg_in [3];
   logic signed [PROD_W-1:0]     prod_pos_ff [3];
   logic signed [PROD_W-1:0]     prod_neg_ff [3];
   logic signed [DIST_W-1:0]     offset_term;
   logic signed [DIST_W-1:0]     dist_pos_in;
   logic signed [DIST_W-1:0]     dist_neg_in;
   logic signed [DIST_W-1:0]     dist_pos_ff;
   logic signed [DIST_W-1:0]     dist_neg_ff;

   assign coef[0] = plane[COEF_W-1:0];
   assign coef[1] = plane[2*COEF_W-1:COEF_W];
   assign coef[2] = plane[3*COEF_W-1:2*COEF_W];
   assign offset  = plane[4*COEF_W-1:3*COEF_W];

   // For a box the positive vertex takes the maximum where the normal
   // component is non-negative; the negative vertex takes the other corner.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         pos_pt[k] = (box_sel && !coef[k][COEF_W-1]) ? hi_pt[k] : lo_pt[k];
         neg_pt[k] = (box_sel &&  coef[k][COEF_W-1]) ? hi_pt[k] : lo_pt[k];
         prod_pos_in[k] = PROD_W'(coef[k]) * PROD_W'(pos_pt[k]);
         prod_neg_in[k] = PROD_W'(coef[k]) * PROD_W'(neg_pt[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en.mul_en) begin
         prod_pos_ff <= prod_pos_in;
         prod_neg_ff <= prod_neg_in;
      end
   end

   // The offset is in coordinate units and is scaled up to the product scale.
   assign offset_term = DIST_W'(offset) <<< NORMAL_FRAC;
   assign dist_pos_in = DIST_W'(prod_pos_ff[0]) + DIST_W'(prod_pos_ff[1])
                      + DIST_W'(prod_pos_ff[2]) + offset_term;
   assign dist_neg_in = DIST_W'(prod_neg_ff[0]) + DIST_W'(prod_neg_ff[1])
                      + DIST_W'(prod_neg_ff[2]) + offset_term;

   always_ff @(posedge clock) begin
      if (stage_en.sum_en) begin
         dist_pos_ff <= dist_pos_in;
         dist_neg_ff <= dist_neg_in;
      end
   end

   assign dist_pos = dist_pos_ff;
   assign dist_neg = dist_neg_ff;

endmodule

`default_nettype wire

/* hw/rtl/frustum_volume_classifier.sv */
// Top level of the frustum volume classifier: pipeline control, per-plane
// test flags and the result register. Depends on fvc_pkg, fvc_csr, fvc_dist.
//
// Usage. Each item on the req_ channel is one bounding volume: a point, a
// sphere (center plus radius) or an axis-aligned box (minimum and maximum
// corners), chosen by req_command; command value 3 is treated as a box.
// The block answers each item with exactly one item on the rsp_ channel
// that classifies the volume against PLANE_COUNT frustum planes as outside,
// fully inside or intersecting. Planes are written through the csr_ port,
// one 64-bit register per plane at byte address 8*i; the user must write
// them only while no item is in flight, as the block does not enforce it.
// The accepting edge loads the input register; the item then passes the
// multiply stage, the distance sum stage, the per-plane compare stage and
// the result register in that order, and rsp_valid rises when it reaches
// the result register. The block takes one item per cycle while rsp_ready
// stays high; every plane has its own set of six multipliers, so no
// unit is shared between items.
// Each stage holds its item when the stage after it is full and stalled,
// and an empty stage always takes a new item, so bubbles close up. While
// the receiver holds rsp_ready low the pipeline keeps filling until all
// five stages hold an item, then req_ready falls; nothing is dropped.
// Reset clears all stage valid bits and all plane registers to zero; with
// zero planes every distance is zero, so points and boxes come out inside
// and spheres with a nonzero radius come out intersecting.
`timescale 1ns / 1ps
`default_nettype none

module frustum_volume_classifier #(
   parameter int PLANE_COUNT = fvc_pkg::DEF_PLANE_COUNT,
   parameter int COORD_BITS  = fvc_pkg::DEF_COORD_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   // Input items.
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [fvc_pkg::CMD_W-1:0]      req_command,
   input  logic signed [COORD_BITS-1:0]   req_point_x,
   input  logic signed [COORD_BITS-1:0]   req_point_y,
   input  logic signed [COORD_BITS-1:0]   req_point_z,
   input  logic signed [COORD_BITS-1:0]   req_far_x,
   input  logic signed [COORD_BITS-1:0]   req_far_y,
   input  logic signed [COORD_BITS-1:0]   req_far_z,
   input  logic [COORD_BITS-2:0]          req_radius,
   // Result items.
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [fvc_pkg::VIS_W-1:0]      rsp_visibility,
   // Configuration port.
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [fvc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [fvc_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [fvc_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import fvc_pkg::*;

   // A product needs COORD_BITS+16 bits; the scaled offset needs 30. Two
   // more bits hold the sum of three products and the offset exactly.
   localparam int PROD_W = COORD_BITS + COEF_W;
   localparam int DIST_W = ((PROD_W > 30) ? PROD_W : 30) + 2;
   localparam int RAD_W  = COORD_BITS - 1;

   logic [PLANE_W-1:0] planes [NUM_PLANE_REGS];

   fvc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .planes      (planes)
   );

   // Stage valid bits and the ready chain. A stage loads when it is empty
   // or when the stage after it is taking its item.
   logic s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff, rsp_vld_ff;
   logic s1_vld_in, s2_vld_in, s3_vld_in, s4_vld_in, rsp_vld_in;
   logic rdy1, rdy2, rdy3, rdy4, rdy5;

   assign rdy5 = !rsp_vld_ff || rsp_ready;
   assign rdy4 = !s4_vld_ff  || rdy5;
   assign rdy3 = !s3_vld_ff  || rdy4;
   assign rdy2 = !s2_vld_ff  || rdy3;
   assign rdy1 = !s1_vld_ff  || rdy2;

   assign s1_vld_in  = rdy1 ? req_valid : s1_vld_ff;
   assign s2_vld_in  = rdy2 ? s1_vld_ff : s2_vld_ff;
   assign s3_vld_in  = rdy3 ? s2_vld_ff : s3_vld_ff;
   assign s4_vld_in  = rdy4 ? s3_vld_ff : s4_vld_ff;
   assign rsp_vld_in = rdy5 ? s4_vld_ff : rsp_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         s3_vld_ff  <= 1'b0;
         s4_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         s2_vld_ff  <= s2_vld_in;
         s3_vld_ff  <= s3_vld_in;
         s4_vld_ff  <= s4_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   assign req_ready = rdy1;
   assign rsp_valid = rsp_vld_ff;

   // Stage 1: input register.
   logic [CMD_W-1:0]             s1_cmd_ff;
   logic [RAD_W-1:0]             s1_radius_ff;
   logic signed [COORD_BITS-1:0] s1_lo_ff [3];
   logic signed [COORD_BITS-1:0] s1_hi_ff [3];

   always_ff @(posedge clock) begin
      if (rdy1) begin
         s1_cmd_ff    <= req_command;
         s1_radius_ff <= req_radius;
         s1_lo_ff[0]  <= req_point_x;
         s1_lo_ff[1]  <= req_point_y;
         s1_lo_ff[2]  <= req_point_z;
         s1_hi_ff[0]  <= req_far_x;
         s1_hi_ff[1]  <= req_far_y;
         s1_hi_ff[2]  <= req_far_z;
      end
   end

   // Points and spheres test the first corner only; every other command
   // selects the box vertex test.
   logic s1_box;
   assign s1_box = (s1_cmd_ff != CMD_POINT) && (s1_cmd_ff != CMD_SPHERE);

   // Stages 2 and 3 live in the distance units; command and radius ride
   // alongside them.
   logic [CMD_W-1:0] s2_cmd_ff, s3_cmd_ff;
   logic [RAD_W-1:0] s2_radius_ff, s3_radius_ff;

   always_ff @(posedge clock) begin
      if (rdy2) begin
         s2_cmd_ff    <= s1_cmd_ff;
         s2_radius_ff <= s1_radius_ff;
      end
      if (rdy3) begin
         s3_cmd_ff    <= s2_cmd_ff;
         s3_radius_ff <= s2_radius_ff;
      end
   end

   fvc_stage_en_type         stage_en;
   logic signed [DIST_W-1:0] dist_pos [PLANE_COUNT];
   logic signed [DIST_W-1:0] dist_neg [PLANE_COUNT];

   assign stage_en.mul_en = rdy2;
   assign stage_en.sum_en = rdy3;

   for (genvar g = 0; g < PLANE_COUNT; g++) begin : g_plane
      fvc_dist #(
         .COORD_BITS (COORD_BITS),
         .DIST_W     (DIST_W)
      ) u_dist (
         .clock    (clock),
         .stage_en (stage_en),
         .plane    (planes[g]),
         .box_sel  (s1_box),
         .lo_pt    (s1_lo_ff),
         .hi_pt    (s1_hi_ff),
         .dist_pos (dist_pos[g]),
         .dist_neg (dist_neg[g])
      );
   end

   // Stage 4: per-plane outside and intersect flags. The radius is scaled
   // to the distance units. A distance exactly on a bound counts as inside.
   logic signed [DIST_W-1:0] rad_pos;
   logic signed [DIST_W-1:0] rad_neg;
   logic [PLANE_COUNT-1:0]   out_flag_in, out_flag_ff;
   logic [PLANE_COUNT-1:0]   isect_flag_in, isect_flag_ff;

   assign rad_pos = DIST_W'({s3_radius_ff, {NORMAL_FRAC{1'b0}}});
   assign rad_neg = -rad_pos;

   always_comb begin
      for (int i = 0; i < PLANE_COUNT; i++) begin
         unique case (s3_cmd_ff)
            CMD_POINT: begin
               out_flag_in[i]   = dist_pos[i] < 0;
               isect_flag_in[i] = 1'b0;
            end
            CMD_SPHERE: begin
               out_flag_in[i]   = dist_pos[i] < rad_neg;
               isect_flag_in[i] = dist_pos[i] < rad_pos;
            end
            default: begin
               out_flag_in[i]   = dist_pos[i] < 0;
               isect_flag_in[i] = dist_neg[i] < 0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (rdy4) begin
         out_flag_ff   <= out_flag_in;
         isect_flag_ff <= isect_flag_in;
      end
   end

   // Result register: any plane outside wins over any plane intersecting.
   logic [VIS_W-1:0] vis_in, vis_ff;

   always_comb begin
      priority if (|out_flag_ff) begin
         vis_in = VIS_OUTSIDE;
      end else if (|isect_flag_ff) begin
         vis_in = VIS_INTERSECT;
      end else begin
         vis_in = VIS_INSIDE;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy5) begin
         vis_ff <= vis_in;
      end
   end

   assign rsp_visibility = vis_ff;

endmodule

`default_nettype wire

/* tb/fvc_visibility_checker.sv */
// Visibility checker of the frustum volume classifier: mirrors the plane registers
// from the csr_ port, predicts the class of every accepted item and compares results.
// Depends on fvc_pkg.
`timescale 1ns / 1ps

module fvc_visibility_checker #(
   parameter int PLANE_COUNT = fvc_pkg::DEF_PLANE_COUNT,
   parameter int COORD_BITS  = fvc_pkg::DEF_COORD_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  logic [fvc_pkg::CMD_W-1:0]      req_command,
   input  logic signed [COORD_BITS-1:0]   req_point_x,
   input  logic signed [COORD_BITS-1:0]   req_point_y,
   input  logic signed [COORD_BITS-1:0]   req_point_z,
   input  logic signed [COORD_BITS-1:0]   req_far_x,
   input  logic signed [COORD_BITS-1:0]   req_far_y,
   input  logic signed [COORD_BITS-1:0]   req_far_z,
   input  logic [COORD_BITS-2:0]          req_radius,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic [fvc_pkg::VIS_W-1:0]      rsp_visibility,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [fvc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [fvc_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input  logic [fvc_pkg::CSR_DATA_W-1:0] csr_prdata,
   input  logic                           csr_pready,
   output int                             fail_count,
   output int                             outstanding
);
   import fvc_pkg::*;

   logic [PLANE_W-1:0] plane_mirror [NUM_PLANE_REGS];
   logic [VIS_W-1:0]   pending_visibility [$];

   // Exact signed distance in Q.18 units; d is scaled up to match the products.
   function automatic longint plane_distance(input logic [PLANE_W-1:0] plane,
                                             input longint x, input longint y,
                                             input longint z);
      longint a, b, c, d;
      a = $signed(plane[15:0]);
      b = $signed(plane[31:16]);
      c = $signed(plane[47:32]);
      d = $signed(plane[63:48]);
      return a * x + b * y + c * z + d * (longint'(1) << NORMAL_FRAC);
   endfunction

   function automatic logic [VIS_W-1:0] classify_volume(
      input logic [CMD_W-1:0] cmd,
      input longint lx, input longint ly, input longint lz,
      input longint hx, input longint hy, input longint hz,
      input longint rad);
      logic [VIS_W-1:0]   vis;
      logic [PLANE_W-1:0] pl;
      longint             reach, center_dist, d_pos, d_neg;
      logic               ax_pos, ay_pos, az_pos;
      vis   = VIS_INSIDE;
      reach = rad * (longint'(1) << NORMAL_FRAC);
      for (int i = 0; i < PLANE_COUNT && i < NUM_PLANE_REGS && vis != VIS_OUTSIDE; i++) begin
         pl = plane_mirror[i];
         case (cmd)
            CMD_POINT: begin
               if (plane_distance(pl, lx, ly, lz) < 0) vis = VIS_OUTSIDE;
            end
            CMD_SPHERE: begin
               center_dist = plane_distance(pl, lx, ly, lz);
               if (center_dist < -reach) vis = VIS_OUTSIDE;
               else if (center_dist < reach) vis = VIS_INTERSECT;
            end
            default: begin
               // Boxes and the unused command code: the positive vertex takes the
               // maximum on axes whose coefficient is not negative.
               ax_pos = !pl[15];
               ay_pos = !pl[31];
               az_pos = !pl[47];
               d_pos = plane_distance(pl, ax_pos ? hx : lx, ay_pos ? hy : ly,
                                      az_pos ? hz : lz);
               d_neg = plane_distance(pl, ax_pos ? lx : hx, ay_pos ? ly : hy,
                                      az_pos ? lz : hz);
               if (d_pos < 0) vis = VIS_OUTSIDE;
               else if (d_neg < 0) vis = VIS_INTERSECT;
            end
         endcase
      end
      return vis;
   endfunction

   task automatic note_failure(input string what, input logic [63:0] want,
                               input logic [63:0] got);
      fail_count++;
      if (fail_count <= 10)
         $display("%0t mismatch: %s expected %h actual %h", $realtime, what, want, got);
   endtask

   always @(posedge clock) begin : watch
      int               idx;
      logic [VIS_W-1:0] want;
      if (reset) begin
         for (int i = 0; i < NUM_PLANE_REGS; i++) plane_mirror[i] = '0;
         pending_visibility.delete();
         fail_count  = 0;
         outstanding = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pready) begin
            idx = int'(csr_paddr >> CSR_BYTE_BITS);
            if (idx < NUM_PLANE_REGS) begin
               if (csr_pwrite) plane_mirror[idx] = csr_pwdata;
               else if (csr_prdata !== plane_mirror[idx])
                  note_failure("plane register readback", plane_mirror[idx], csr_prdata);
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_visibility.size() == 0) begin
               note_failure("result with none pending", '0, 64'(rsp_visibility));
            end else begin
               want = pending_visibility.pop_front();
               if (rsp_visibility !== want)
                  note_failure("visibility", 64'(want), 64'(rsp_visibility));
            end
         end
         if (req_valid && req_ready)
            pending_visibility.push_back(classify_volume(req_command,
               req_point_x, req_point_y, req_point_z,
               req_far_x, req_far_y, req_far_z, longint'(req_radius)));
         outstanding = pending_visibility.size();
      end
   end

endmodule

/* tb/tb_frustum_volume_classifier.sv */
// Testbench top of the frustum volume classifier: clock, reset, stimulus and verdict.
// Depends on fvc_pkg, frustum_volume_classifier and fvc_visibility_checker.
`timescale 1ns / 1ps

module tb_frustum_volume_classifier;
   import fvc_pkg::*;

   localparam int COORD_BITS        = DEF_COORD_BITS;
   localparam int ITEMS_PER_SEGMENT = 200;
   localparam int SEGMENTS          = 8;
   localparam int HOLD_OFF_CYCLES   = 60;
   localparam int LATENCY           = 5;

   // The command field has one code the block does not name; it must act as a box.
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   // 1.0 and -1.0 in the Q1.14 normal format.
   localparam logic [COEF_W-1:0] NORMAL_ONE     = 16'h4000;
   localparam logic [COEF_W-1:0] NORMAL_NEG_ONE = 16'hC000;

   typedef enum int {
      PLANES_CUBE,
      PLANES_RANDOM,
      PLANES_EXTREME,
      PLANES_TILTED
   } plane_set_type;

   typedef struct packed {
      logic [CMD_W-1:0]      command;
      logic [COORD_BITS-1:0] point_x;
      logic [COORD_BITS-1:0] point_y;
      logic [COORD_BITS-1:0] point_z;
      logic [COORD_BITS-1:0] far_x;
      logic [COORD_BITS-1:0] far_y;
      logic [COORD_BITS-1:0] far_z;
      logic [COORD_BITS-2:0] radius;
   } volume_type;

   logic                         clock = 1'b0;
   logic                         reset;
   logic                         req_valid;
   logic                         req_ready;
   logic [CMD_W-1:0]             req_command;
   logic signed [COORD_BITS-1:0] req_point_x, req_point_y, req_point_z;
   logic signed [COORD_BITS-1:0] req_far_x, req_far_y, req_far_z;
   logic [COORD_BITS-2:0]        req_radius;
   logic                         rsp_valid;
   logic                         rsp_ready;
   logic [VIS_W-1:0]             rsp_visibility;
   logic                         csr_psel, csr_penable, csr_pwrite;
   logic [CSR_ADDR_W-1:0]        csr_paddr;
   logic [CSR_DATA_W-1:0]        csr_pwdata;
   logic [CSR_DATA_W-1:0]        csr_prdata;
   logic                         csr_pready;

   int fail_count;
   int outstanding;

   // Knobs owned by stimulus; the response side reads stall_pct and hold_requests.
   int idle_pct;
   int stall_pct;
   int hold_requests;
   int coord_span;

   always #1 clock = ~clock;

   frustum_volume_classifier u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_command    (req_command),
      .req_point_x    (req_point_x),
      .req_point_y    (req_point_y),
      .req_point_z    (req_point_z),
      .req_far_x      (req_far_x),
      .req_far_y      (req_far_y),
      .req_far_z      (req_far_z),
      .req_radius     (req_radius),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_visibility (rsp_visibility),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   fvc_visibility_checker u_visibility_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_command    (req_command),
      .req_point_x    (req_point_x),
      .req_point_y    (req_point_y),
      .req_point_z    (req_point_z),
      .req_far_x      (req_far_x),
      .req_far_y      (req_far_y),
      .req_far_z      (req_far_z),
      .req_radius     (req_radius),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_visibility (rsp_visibility),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready),
      .fail_count     (fail_count),
      .outstanding    (outstanding)
   );

   // A plane register holds a, b, c and d from the low half-word up.
   function automatic logic [PLANE_W-1:0] pack_plane(input logic [COEF_W-1:0] a,
                                                     input logic [COEF_W-1:0] b,
                                                     input logic [COEF_W-1:0] c,
                                                     input logic [COEF_W-1:0] d);
      return {d, c, b, a};
   endfunction

   // Planes of an axis-aligned cube of the given half size around the origin.
   // Even indexes face the positive axis direction, odd ones the negative.
   function automatic logic [PLANE_W-1:0] cube_plane(input int idx,
                                                     input logic [COEF_W-1:0] half);
      logic [COEF_W-1:0] normal;
      normal = (idx % 2 == 0) ? NORMAL_ONE : NORMAL_NEG_ONE;
      case (idx / 2)
         0:       return pack_plane(normal, '0, '0, half);
         1:       return pack_plane('0, normal, '0, half);
         default: return pack_plane('0, '0, normal, half);
      endcase
   endfunction

   function automatic logic [COEF_W-1:0] extreme_value();
      case ($urandom_range(3))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return 16'h0000;
         default: return 16'hFFFF;
      endcase
   endfunction

   function automatic volume_type volume(input logic [CMD_W-1:0] cmd,
                                         input int px, input int py, input int pz,
                                         input int fx, input int fy, input int fz,
                                         input int rad);
      volume_type v;
      v.command = cmd;
      v.point_x = COORD_BITS'(px);
      v.point_y = COORD_BITS'(py);
      v.point_z = COORD_BITS'(pz);
      v.far_x   = COORD_BITS'(fx);
      v.far_y   = COORD_BITS'(fy);
      v.far_z   = COORD_BITS'(fz);
      v.radius  = (COORD_BITS-1)'(rad);
      return v;
   endfunction

   // Most coordinates land near the current frustum so that all three classes
   // come up often; the rest cover the full range and its corners.
   function automatic logic [COORD_BITS-1:0] random_coord();
      case ($urandom_range(7))
         0:       return COORD_BITS'($urandom);
         1:       return extreme_value();
         default: return COORD_BITS'($urandom_range(2 * coord_span) - coord_span);
      endcase
   endfunction

   function automatic volume_type random_volume();
      volume_type            v;
      int                    pick;
      logic [COORD_BITS-1:0] swap;
      pick = $urandom_range(9);
      if (pick < 3)      v.command = CMD_POINT;
      else if (pick < 6) v.command = CMD_SPHERE;
      else if (pick < 9) v.command = CMD_BOX;
      else               v.command = CMD_UNUSED;
      v.point_x = random_coord();
      v.point_y = random_coord();
      v.point_z = random_coord();
      v.far_x   = random_coord();
      v.far_y   = random_coord();
      v.far_z   = random_coord();
      v.radius  = ($urandom_range(3) == 0) ? (COORD_BITS-1)'($urandom)
                                           : (COORD_BITS-1)'($urandom_range(400));
      // Three boxes in four are well ordered; the rest may be inverted on any axis.
      if ($urandom_range(3) != 0) begin
         if ($signed(v.point_x) > $signed(v.far_x)) begin
            swap = v.point_x; v.point_x = v.far_x; v.far_x = swap;
         end
         if ($signed(v.point_y) > $signed(v.far_y)) begin
            swap = v.point_y; v.point_y = v.far_y; v.far_y = swap;
         end
         if ($signed(v.point_z) > $signed(v.far_z)) begin
            swap = v.point_z; v.point_z = v.far_z; v.far_z = swap;
         end
      end
      return v;
   endfunction

   // One APB transfer: setup cycle, then access until pready. Starts and ends
   // at a falling edge.
   task automatic csr_access(input logic write, input int idx,
                             input logic [CSR_DATA_W-1:0] data);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = write;
      csr_paddr   = CSR_ADDR_W'(idx << CSR_BYTE_BITS);
      csr_pwdata  = data;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
   endtask

   // Writes a plane and reads it back; the checker compares the read data.
   task automatic program_plane(input int idx, input logic [PLANE_W-1:0] value);
      csr_access(1'b1, idx, value);
      csr_access(1'b0, idx, '0);
   endtask

   task automatic load_planes(input plane_set_type set);
      logic [COEF_W-1:0]  half;
      logic [PLANE_W-1:0] value;
      half       = COEF_W'($urandom_range(3000, 40));
      coord_span = 2 * int'(half) + 200;
      for (int i = 0; i < NUM_PLANE_REGS; i++) begin
         case (set)
            PLANES_CUBE:    value = cube_plane(i, half);
            PLANES_RANDOM:  value = {$urandom, $urandom};
            PLANES_EXTREME: value = pack_plane(extreme_value(), extreme_value(),
                                               extreme_value(), extreme_value());
            default:        value = pack_plane(COEF_W'($urandom_range(32767) - 16384),
                                               COEF_W'($urandom_range(32767) - 16384),
                                               COEF_W'($urandom_range(32767) - 16384),
                                               COEF_W'($urandom_range(2 * half) - half));
         endcase
         program_plane(i, value);
      end
   endtask

   // Offers one item, possibly after a random idle stretch, and returns at the
   // falling edge after it was taken. valid stays high on return so that
   // back-to-back items do not drop it; the next call or drain decides.
   task automatic send_volume(input volume_type v);
      while ($urandom_range(99) < idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_command = v.command;
      req_point_x = v.point_x;
      req_point_y = v.point_y;
      req_point_z = v.point_z;
      req_far_x   = v.far_x;
      req_far_y   = v.far_y;
      req_far_z   = v.far_z;
      req_radius  = v.radius;
      req_valid   = 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Stops offering items and waits until every predicted result has arrived.
   task automatic drain();
      req_valid = 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   // Result side. A long hold-off is requested by bumping hold_requests; it
   // is counted here so that the stimulus keeps pushing items meanwhile.
   initial begin : result_sink
      int hold_left;
      int holds_served;
      hold_left    = 0;
      holds_served = 0;
      rsp_ready    = 1'b0;
      forever begin
         @(negedge clock);
         if (holds_served != hold_requests) begin
            holds_served = hold_requests;
            hold_left    = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready = 1'b0;
         end else begin
            rsp_ready = ($urandom_range(99) >= stall_pct);
         end
      end
   end

   initial begin : stimulus
      logic [PLANE_W-1:0] corner_plane;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_command   = CMD_POINT;
      req_point_x   = '0;
      req_point_y   = '0;
      req_point_z   = '0;
      req_far_x     = '0;
      req_far_y     = '0;
      req_far_z     = '0;
      req_radius    = '0;
      csr_psel      = 1'b0;
      csr_penable   = 1'b0;
      csr_pwrite    = 1'b0;
      csr_paddr     = '0;
      csr_pwdata    = '0;
      idle_pct      = 0;
      stall_pct     = 0;
      hold_requests = 0;
      coord_span    = 2000;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      // Planes straight out of reset are all zero, so every distance is zero:
      // points and boxes are inside, a sphere is inside only with zero radius.
      send_volume(volume(CMD_POINT, -32768, 32767, 0, 0, 0, 0, 0));
      send_volume(volume(CMD_SPHERE, 5, -5, 7, 0, 0, 0, 0));
      send_volume(volume(CMD_SPHERE, 5, -5, 7, 0, 0, 0, 1));
      send_volume(volume(CMD_BOX, -32768, -32768, -32768, 32767, 32767, 32767, 0));
      send_volume(volume(CMD_UNUSED, 10, 10, 10, -10, -10, -10, 32767));
      drain();

      // A cube of half size 100.0 (1600 in Q11.4) gives exact boundary cases.
      for (int i = 0; i < NUM_PLANE_REGS; i++) program_plane(i, cube_plane(i, 16'd1600));
      send_volume(volume(CMD_POINT, 0, 0, 0, 0, 0, 0, 0));
      // A point right on a plane counts as inside it.
      send_volume(volume(CMD_POINT, -1600, 0, 0, 0, 0, 0, 0));
      send_volume(volume(CMD_POINT, -1601, 0, 0, 0, 0, 0, 0));
      send_volume(volume(CMD_POINT, 32767, 0, 0, 0, 0, 0, 0));
      // Far corner and radius are ignored for a point.
      send_volume(volume(CMD_POINT, 0, 0, 0, -32768, 32767, -32768, 32767));
      send_volume(volume(CMD_SPHERE, 0, 0, 0, 32767, 32767, 32767, 0));
      // A sphere whose distance is exactly minus its radius is not outside,
      // and one exactly at plus its radius is not intersecting.
      send_volume(volume(CMD_SPHERE, -1650, 0, 0, 0, 0, 0, 50));
      send_volume(volume(CMD_SPHERE, -1651, 0, 0, 0, 0, 0, 50));
      send_volume(volume(CMD_SPHERE, 0, 1550, 0, 0, 0, 0, 50));
      send_volume(volume(CMD_SPHERE, 0, 1551, 0, 0, 0, 0, 50));
      send_volume(volume(CMD_SPHERE, 0, 0, 0, 0, 0, 0, 32767));
      send_volume(volume(CMD_BOX, -100, -100, -100, 100, 100, 100, 32767));
      send_volume(volume(CMD_BOX, -2000, -2000, -2000, 0, 0, 0, 0));
      send_volume(volume(CMD_BOX, 2000, 0, 0, 3000, 10, 10, 0));
      // Inverted box: the corners are still picked by coefficient sign only.
      send_volume(volume(CMD_BOX, 100, 100, 100, -100, -100, -100, 0));
      send_volume(volume(CMD_UNUSED, -1700, -10, -10, -1500, 10, 10, 0));
      drain();

      // Every field at its most negative value makes the largest products.
      corner_plane = pack_plane(16'h8000, 16'h8000, 16'h8000, 16'h8000);
      for (int i = 0; i < NUM_PLANE_REGS; i++) program_plane(i, corner_plane);
      send_volume(volume(CMD_POINT, -32768, -32768, -32768, 0, 0, 0, 0));
      send_volume(volume(CMD_SPHERE, 32767, 32767, 32767, 0, 0, 0, 32767));
      send_volume(volume(CMD_BOX, -32768, -32768, -32768, 32767, 32767, 32767, 0));
      drain();

      // Random part: each segment loads a fresh plane set while the pipeline is
      // empty and runs under one of four idle patterns: none, sender idle,
      // receiver stalling, and both.
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         drain();
         load_planes(plane_set_type'(seg % 4));
         case (seg / 2)
            0:       begin idle_pct = 0;  stall_pct = 0;  end
            1:       begin idle_pct = 45; stall_pct = 0;  end
            2:       begin idle_pct = 0;  stall_pct = 45; end
            default: begin idle_pct = 28; stall_pct = 28; end
         endcase
         // With the sender never idle, a long receiver hold-off fills all
         // pipeline stages and must push back on the input.
         if (seg == 1) hold_requests++;
         for (int n = 0; n < ITEMS_PER_SEGMENT; n++) begin
            // Halfway through one segment the sender waits for a full drain.
            if (seg == 5 && n == ITEMS_PER_SEGMENT / 2) drain();
            send_volume(random_volume());
         end
      end

      drain();
      repeat (2 * LATENCY) @(negedge clock);
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Far beyond the slowest correct run.
   initial begin : watchdog
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
